/* src/cal_pkg.sv */
package cal_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [3:0] OP_INS_BEFORE = 4'd0;
    localparam logic [3:0] OP_INS_AFTER  = 4'd1;
    localparam logic [3:0] OP_READ       = 4'd2;
    localparam logic [3:0] OP_REMOVE     = 4'd3;
    localparam logic [3:0] OP_CLEAR      = 4'd4;
    localparam logic [3:0] OP_FIRST      = 4'd5;
    localparam logic [3:0] OP_LAST       = 4'd6;
    localparam logic [3:0] OP_NEXT       = 4'd7;
    localparam logic [3:0] OP_PRIOR      = 4'd8;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] value;
    } cal_cmd_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] read_value;
        logic [CNT_W-1:0]   item_count;
        logic [IDX_W-1:0]   cursor_pos;
    } cal_rsp_t;

    // Kind of work that an accepted command needs after decode
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_READ   = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_INSERT = 2'd3
    } cal_act_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic fetch;
        logic shift;
        logic fill;
    } cal_ctl_t;

    typedef struct packed {
        cal_act_t act;
        cal_act_t act_held;
        logic     shift_done;
    } cal_status_t;

endpackage

/* src/cal_ctrl.sv */
module cal_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  cal_pkg::cal_status_t status,
    output cal_pkg::cal_ctl_t    ctl,
    output logic                 busy,
    output logic                 done
);
    import cal_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_FETCH = 6'b000100,
        S_SHIFT = 6'b001000,
        S_FILL  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                ctl.eval = 1'b1;
                case (status.act)
                    ACT_READ:   state_next = S_FETCH;
                    ACT_REMOVE: state_next = S_FETCH;
                    ACT_INSERT: state_next = S_SHIFT;
                    default:    state_next = S_DONE;
                endcase
            end
            S_FETCH:
            begin
                ctl.fetch = 1'b1;
                if (status.act_held == ACT_REMOVE)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                ctl.shift = 1'b1;
                if (status.shift_done)
                begin
                    if (status.act_held == ACT_INSERT)
                    begin
                        state_next = S_FILL;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_FILL:
            begin
                ctl.fill   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

/* src/cal_dp.sv */
module cal_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cal_pkg::cal_cmd_t           cmd,
    input  logic                        cfg_we,
    input  logic [cal_pkg::CNT_W-1:0]   cfg_wdata,
    input  cal_pkg::cal_ctl_t           ctl,
    output cal_pkg::cal_status_t        status,
    output cal_pkg::cal_rsp_t           result
);
    import cal_pkg::*;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;

    logic [3:0]         op_reg;
    logic signed [31:0] value_reg;
    logic [CNT_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   cursor_reg;
    cal_act_t           act_reg;
    logic [CNT_W-1:0]   left_reg;
    logic               wpend_reg;
    logic [IDX_W-1:0]   src_reg;
    logic [IDX_W-1:0]   dst_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic               ok_reg;
    logic signed [31:0] rd_reg;

    logic [CNT_W-1:0]   eff_cap;
    logic               empty;
    logic               full;
    logic [CNT_W-1:0]   cur_ext;
    logic [CNT_W-1:0]   cur_inc;
    logic [CNT_W-1:0]   cnt_dec;
    logic               cur_lt;

    logic               ok_c;
    cal_act_t           act_c;
    logic [CNT_W-1:0]   cnt_c;
    logic [IDX_W-1:0]   cur_c;
    logic [IDX_W-1:0]   pos_c;
    logic [CNT_W-1:0]   left_c;
    logic [IDX_W-1:0]   src_c;
    logic [IDX_W-1:0]   dst_c;

    logic               shift_up;
    logic [IDX_W-1:0]   raddr;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(DEPTH))
        begin
            eff_cap = CNT_W'(DEPTH);
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    assign empty   = (count_reg == '0);
    assign full    = (count_reg >= eff_cap);
    assign cur_ext = CNT_W'(cursor_reg);
    assign cur_inc = cur_ext + CNT_W'(1);
    assign cnt_dec = count_reg - CNT_W'(1);
    assign cur_lt  = (cur_ext < count_reg);

    // Decode the held command against the current list state
    always_comb
    begin
        ok_c   = 1'b0;
        act_c  = ACT_NONE;
        cnt_c  = count_reg;
        cur_c  = cursor_reg;
        pos_c  = cursor_reg;
        left_c = '0;
        src_c  = IDX_W'(cnt_dec);
        dst_c  = IDX_W'(count_reg);
        case (op_reg)
            OP_INS_BEFORE:
            begin
                if (!empty && !full && cur_lt)
                begin
                    ok_c   = 1'b1;
                    act_c  = ACT_INSERT;
                    cnt_c  = count_reg + CNT_W'(1);
                    left_c = count_reg - cur_ext;
                end
            end
            OP_INS_AFTER:
            begin
                if (!full)
                begin
                    ok_c  = 1'b1;
                    act_c = ACT_INSERT;
                    cnt_c = count_reg + CNT_W'(1);
                    if (empty)
                    begin
                        cur_c = '0;
                        pos_c = '0;
                    end
                    else
                    begin
                        cur_c  = IDX_W'(cur_inc);
                        pos_c  = IDX_W'(cur_inc);
                        left_c = count_reg - cur_inc;
                    end
                end
            end
            OP_READ:
            begin
                if (!empty && cur_lt)
                begin
                    ok_c  = 1'b1;
                    act_c = ACT_READ;
                end
            end
            OP_REMOVE:
            begin
                if (!empty && cur_lt)
                begin
                    ok_c   = 1'b1;
                    act_c  = ACT_REMOVE;
                    cnt_c  = cnt_dec;
                    left_c = count_reg - cur_inc;
                    src_c  = IDX_W'(cur_inc);
                    dst_c  = cursor_reg;
                    if (cnt_dec == '0)
                    begin
                        cur_c = '0;
                    end
                    else if (cur_ext >= cnt_dec)
                    begin
                        cur_c = IDX_W'(cnt_dec - CNT_W'(1));
                    end
                end
            end
            OP_CLEAR:
            begin
                ok_c  = 1'b1;
                cnt_c = '0;
                cur_c = '0;
            end
            OP_FIRST:
            begin
                if (!empty)
                begin
                    ok_c  = 1'b1;
                    cur_c = '0;
                end
            end
            OP_LAST:
            begin
                if (!empty)
                begin
                    ok_c  = 1'b1;
                    cur_c = IDX_W'(cnt_dec);
                end
            end
            OP_NEXT:
            begin
                if (!empty && cur_inc < count_reg)
                begin
                    ok_c  = 1'b1;
                    cur_c = IDX_W'(cur_inc);
                end
            end
            OP_PRIOR:
            begin
                if (!empty && cursor_reg != '0)
                begin
                    ok_c  = 1'b1;
                    cur_c = cursor_reg - IDX_W'(1);
                end
            end
            default:
            begin
                ok_c = 1'b0;
            end
        endcase
    end

    assign shift_up = (act_reg == ACT_INSERT);
    assign raddr    = ctl.shift ? src_reg : cursor_reg;

    // Storage: one registered read and one write per cycle
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
        if (ctl.shift && wpend_reg)
        begin
            mem[dst_reg] <= rdata_reg;
        end
        else if (ctl.fill)
        begin
            mem[pos_reg] <= value_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_RESET;
            count_reg  <= '0;
            cursor_reg <= '0;
            act_reg    <= ACT_NONE;
            left_reg   <= '0;
            wpend_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (ctl.eval)
            begin
                count_reg  <= cnt_c;
                cursor_reg <= cur_c;
                act_reg    <= act_c;
                left_reg   <= left_c;
                wpend_reg  <= 1'b0;
            end
            else if (ctl.shift)
            begin
                wpend_reg <= (left_reg != '0);
                if (left_reg != '0)
                begin
                    left_reg <= left_reg - CNT_W'(1);
                end
            end
        end
    end

    // Payload and address registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg    <= cmd.op;
            value_reg <= cmd.value;
        end
        if (ctl.eval)
        begin
            ok_reg  <= ok_c;
            rd_reg  <= '0;
            pos_reg <= pos_c;
            src_reg <= src_c;
            dst_reg <= dst_c;
        end
        if (ctl.fetch)
        begin
            rd_reg <= rdata_reg;
        end
        if (ctl.shift)
        begin
            if (left_reg != '0)
            begin
                src_reg <= shift_up ? src_reg - IDX_W'(1) : src_reg + IDX_W'(1);
            end
            if (wpend_reg)
            begin
                dst_reg <= shift_up ? dst_reg - IDX_W'(1) : dst_reg + IDX_W'(1);
            end
        end
    end

    assign status.act        = act_c;
    assign status.act_held   = act_reg;
    assign status.shift_done = (left_reg == '0) && !wpend_reg;

    assign result.ok         = ok_reg;
    assign result.read_value = rd_reg;
    assign result.item_count = count_reg;
    assign result.cursor_pos = (count_reg == '0) ? '0 : cursor_reg;

endmodule

/* src/cursor_array_list_engine_unit.sv */
// Cursor list engine: an ordered list of signed 32-bit words in a 16-entry
// store, with an item count and a cursor.
//
// Command channel: drive cmd (op, value) and raise start; the transfer
// happens at the clock edge where start is high and busy is low. busy stays
// high until the result has been shown.
// Result channel: done is high for exactly one cycle with result (ok,
// read_value, item_count, cursor_pos) valid in that cycle. The receiver
// cannot stall, so it must take the transfer in that cycle.
// Config: cfg_we with cfg_wdata writes the capacity register; write it
// only while busy is low.
//
// After accept, cursor moves, clear and refusals go from decode to done;
// a read adds a fetch; a remove fetches, then shifts n entries, and an
// insert shifts n entries, then fills, where n (at most 15) is the number
// of entries that shift, possibly none. Shifting moves one entry per cycle
// through the one read and one write port of the store. busy drops the
// cycle after done.
// Reset clears count, cursor and the control state and sets capacity to
// 16; no clearing pass runs, the store needs none.
module cursor_array_list_engine_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  cal_pkg::cal_cmd_t           cmd,
    output logic                        busy,
    output logic                        done,
    output cal_pkg::cal_rsp_t           result,
    input  logic                        cfg_we,
    input  logic [cal_pkg::CNT_W-1:0]   cfg_wdata
);
    import cal_pkg::*;

    cal_ctl_t    ctl;
    cal_status_t status;

    // Sequencer: accept, decode, fetch, shift, fill, report
    cal_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctl    (ctl),
        .busy   (busy),
        .done   (done)
    );

    // List store, count, cursor, capacity and result registers
    cal_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .status    (status),
        .result    (result)
    );

endmodule

/* dv/tb_cursor_array_list_engine_unit.sv */
module tb_cursor_array_list_engine_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import cal_pkg::*;

    // Op codes with no operation behind them; the block must refuse them
    localparam logic [3:0] OP_UNUSED_LO = 4'd9;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    // Quiet cycles (no command and no result transfer) before giving up
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to let pass after the last result before a register write or the end
    localparam int SETTLE_CYCLES  = DEPTH + 8;
    // Stop printing mismatch lines past this many; keep counting
    localparam int MAX_PRINTED    = 100;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    cal_cmd_t         cmd = '0;
    logic             busy;
    logic             done;
    cal_rsp_t         result;
    logic             cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;

    cursor_array_list_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the list: words, count, cursor and the capacity register
    logic signed [31:0] list_words [DEPTH];
    logic [CNT_W-1:0]   held_count = '0;
    logic [IDX_W-1:0]   list_cursor = '0;
    logic [CNT_W-1:0]   list_capacity = CAP_RESET;

    // Results still owed by the block, oldest first
    cal_rsp_t expected_rsp_q [$];
    cal_rsp_t want_rsp;

    int  mismatch_count = 0;
    int  cmds_sent = 0;
    int  results_seen = 0;
    int  refusals_seen = 0;
    int  full_hits = 0;
    int  quiet_cycles = 0;
    bit  no_idle = 1'b0;

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        foreach (list_words[i]) list_words[i] = '0;
    end

    // ------------------------------------------------------------------
    // Predictor: apply one command to the shadow list and return the
    // result the block should show for it.
    // ------------------------------------------------------------------
    function automatic cal_rsp_t predict_list_op(input cal_cmd_t c);
        cal_rsp_t         r;
        logic [CNT_W-1:0] limit;
        bit               empty;
        bit               full;
        int               i;
        r = '0;
        // A capacity of zero behaves as one, anything above DEPTH as DEPTH
        if (list_capacity == '0)
            limit = CNT_W'(1);
        else if (list_capacity > CNT_W'(DEPTH))
            limit = CNT_W'(DEPTH);
        else
            limit = list_capacity;
        empty = (held_count == '0);
        full  = (held_count >= limit);
        case (c.op)
            OP_INS_BEFORE:
                if (!empty && !full && list_cursor < held_count)
                begin
                    for (i = int'(held_count); i > list_cursor; i--)
                        list_words[i] = list_words[i-1];
                    list_words[list_cursor] = c.value;
                    held_count++;
                    r.ok = 1'b1;
                end
            OP_INS_AFTER:
                if (!full)
                begin
                    if (empty)
                    begin
                        list_cursor   = '0;
                        list_words[0] = c.value;
                    end
                    else
                    begin
                        for (i = int'(held_count); i > list_cursor + 1; i--)
                            list_words[i] = list_words[i-1];
                        list_cursor++;
                        list_words[list_cursor] = c.value;
                    end
                    held_count++;
                    r.ok = 1'b1;
                end
            OP_READ:
                if (!empty && list_cursor < held_count)
                begin
                    r.read_value = list_words[list_cursor];
                    r.ok = 1'b1;
                end
            OP_REMOVE:
                if (!empty && list_cursor < held_count)
                begin
                    r.read_value = list_words[list_cursor];
                    for (i = int'(list_cursor); i + 1 < held_count; i++)
                        list_words[i] = list_words[i+1];
                    held_count--;
                    // Clamp the cursor onto the new tail, or home when empty
                    if (held_count == '0)
                        list_cursor = '0;
                    else if (list_cursor >= held_count)
                        list_cursor = IDX_W'(held_count - 1);
                    r.ok = 1'b1;
                end
            OP_CLEAR:
            begin
                held_count  = '0;
                list_cursor = '0;
                r.ok = 1'b1;
            end
            OP_FIRST:
                if (!empty)
                begin
                    list_cursor = '0;
                    r.ok = 1'b1;
                end
            OP_LAST:
                if (!empty)
                begin
                    list_cursor = IDX_W'(held_count - 1);
                    r.ok = 1'b1;
                end
            OP_NEXT:
                if (!empty && list_cursor + 1 < held_count)
                begin
                    list_cursor++;
                    r.ok = 1'b1;
                end
            OP_PRIOR:
                if (!empty && list_cursor > '0)
                begin
                    list_cursor--;
                    r.ok = 1'b1;
                end
            default: ;
        endcase
        r.item_count = held_count;
        r.cursor_pos = (held_count == '0) ? '0 : list_cursor;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // Command side. Call only right after a rising edge. Start stays high
    // across back-to-back transfers and drops only for an idle gap.
    // ------------------------------------------------------------------
    task automatic send_list_op(input logic [3:0] op, input logic signed [31:0] word);
        cal_cmd_t c;
        c.op    = op;
        c.value = word;
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        // Hold the command until the block takes it
        while (busy) @(posedge clk);
        expected_rsp_q.push_back(predict_list_op(c));
        cmds_sent++;
        // Idle about a quarter of the time, unless in the no-idle stretch
        if (!no_idle && $urandom_range(0, 99) < 25)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Drop start, wait for every owed result, then let the block settle
    task automatic drain_and_settle();
        start <= 1'b0;
        @(posedge clk);
        while (expected_rsp_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the capacity register; only ever with the block idle
    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        drain_and_settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
        list_capacity = cap;
    endtask

    function automatic logic signed [31:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        // Lean on the extremes now and then, otherwise any word
        if (r < 3)
            return 32'sh8000_0000;
        else if (r < 6)
            return 32'sh7FFF_FFFF;
        else if (r < 8)
            return '0;
        else if (r < 10)
            return -32'sd1;
        return $urandom;
    endfunction

    // Pick an op, leaning toward inserts while filling and removes while draining
    function automatic logic [3:0] pick_list_op(input bit filling);
        int r;
        int r2;
        int ins_w;
        int rem_w;
        r     = $urandom_range(0, 99);
        ins_w = filling ? 50 : 15;
        rem_w = filling ? 8 : 35;
        if (r < ins_w / 2)
            return OP_INS_BEFORE;
        if (r < ins_w)
            return OP_INS_AFTER;
        if (r < ins_w + rem_w)
            return OP_REMOVE;
        if (r < ins_w + rem_w + 10)
            return OP_READ;
        r2 = $urandom_range(0, 99);
        if (r2 < 3)
            return OP_CLEAR;
        if (r2 < 8)
            return 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        case (r2 % 4)
            0:       return OP_FIRST;
            1:       return OP_LAST;
            2:       return OP_NEXT;
            default: return OP_PRIOR;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: the block cannot be stalled, so take every done pulse
    // and match it against the oldest owed result, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_rsp_q.size() == 0)
                report_mismatch("result transfer with no command outstanding");
            else
            begin
                want_rsp = expected_rsp_q.pop_front();
                if (!want_rsp.ok)
                    refusals_seen++;
                if (want_rsp.ok && want_rsp.item_count == CNT_W'(DEPTH))
                    full_hits++;
                if (result.ok !== want_rsp.ok)
                    report_mismatch($sformatf("result %0d: ok %b, want %b",
                        results_seen, result.ok, want_rsp.ok));
                if (result.read_value !== want_rsp.read_value)
                    report_mismatch($sformatf("result %0d: read_value %h, want %h",
                        results_seen, result.read_value, want_rsp.read_value));
                if (result.item_count !== want_rsp.item_count)
                    report_mismatch($sformatf("result %0d: item_count %0d, want %0d",
                        results_seen, result.item_count, want_rsp.item_count));
                if (result.cursor_pos !== want_rsp.cursor_pos)
                    report_mismatch($sformatf("result %0d: cursor_pos %0d, want %0d",
                        results_seen, result.cursor_pos, want_rsp.cursor_pos));
            end
        end
    end

    // Watchdog: count cycles with neither a command nor a result transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every op that needs an item must be refused on an empty list;
    // unused op codes are refused too.
    task automatic test_empty_list_refusals();
        send_list_op(OP_READ, 32'sd5);
        send_list_op(OP_REMOVE, 32'sd5);
        send_list_op(OP_FIRST, '0);
        send_list_op(OP_LAST, '0);
        send_list_op(OP_NEXT, '0);
        send_list_op(OP_PRIOR, '0);
        send_list_op(OP_INS_BEFORE, 32'sh1234_5678);
        send_list_op(OP_UNUSED_LO, -32'sd1);
        send_list_op(OP_UNUSED_HI, -32'sd1);
    endtask

    // Build a short list from the extreme words and walk the cursor into
    // both ends, then remove at the tail (cursor clamps) and at the head.
    task automatic test_cursor_walk();
        send_list_op(OP_INS_AFTER, 32'sh8000_0000);
        send_list_op(OP_INS_AFTER, 32'sh7FFF_FFFF);
        send_list_op(OP_INS_BEFORE, -32'sd1);
        send_list_op(OP_READ, '0);
        send_list_op(OP_NEXT, '0);
        send_list_op(OP_NEXT, '0);
        send_list_op(OP_PRIOR, '0);
        send_list_op(OP_PRIOR, '0);
        send_list_op(OP_PRIOR, '0);
        send_list_op(OP_LAST, '0);
        send_list_op(OP_REMOVE, '0);
        send_list_op(OP_FIRST, '0);
        send_list_op(OP_REMOVE, '0);
        send_list_op(OP_CLEAR, '0);
        send_list_op(OP_READ, '0);
    endtask

    // Small capacities: fill to full, lower the limit under the count,
    // then capacities zero and above DEPTH that the block must clamp.
    task automatic test_capacity_limits();
        write_capacity(CNT_W'(2));
        send_list_op(OP_INS_AFTER, 32'sd11);
        send_list_op(OP_INS_AFTER, 32'sd22);
        send_list_op(OP_INS_AFTER, 32'sd33);
        send_list_op(OP_INS_BEFORE, 32'sd44);
        write_capacity(CNT_W'(1));
        send_list_op(OP_INS_AFTER, 32'sd55);
        send_list_op(OP_READ, '0);
        write_capacity('0);
        send_list_op(OP_REMOVE, '0);
        send_list_op(OP_INS_AFTER, 32'sd66);
        write_capacity('1);
        send_list_op(OP_INS_AFTER, 32'sd77);
    endtask

    // Random traffic over a sweep of capacities; alternate fill-heavy and
    // drain-heavy stretches so the list hits both empty and full.
    task automatic test_random_traffic();
        logic [CNT_W-1:0] caps [8];
        int               phase;
        int               k;
        caps = '{CNT_W'(16), CNT_W'(1), CNT_W'(2), '1, CNT_W'(5), '0, CNT_W'(16),
                 CNT_W'(9)};
        for (phase = 0; phase < 8; phase++)
        begin
            write_capacity(caps[phase]);
            // One long stretch with the command side never idling
            no_idle = (phase == 6);
            for (k = 0; k < 125; k++)
                send_list_op(pick_list_op(((k / 40) % 2) == 0), pick_word());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        // Hold reset low, then release it once
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list_refusals();
        test_cursor_walk();
        test_capacity_limits();
        test_random_traffic();

        drain_and_settle();

        $display("Sent %0d commands and checked %0d results, %0d of them refusals.",
            cmds_sent, results_seen, refusals_seen);
        $display("Capacities between 0 and 31 used; a full 16-entry list was reached %0d times.",
            full_hits);
        if (mismatch_count == 0 && expected_rsp_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
